[rtl/fwrs_pkg.sv]
package fwrs_pkg;

   // Table geometry and field widths.
   localparam int unsigned MAX_SIZE_DEFAULT = 1024;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned POS_W = 11;
   localparam logic [POS_W-1:0] ACTIVE_SIZE_RESET = 11'd1024;

   // Transaction kinds.
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   typedef logic [3:0] upc_type;

   // Walk index operations.
   localparam logic [2:0] IDX_HOLD     = 3'd0;
   localparam logic [2:0] IDX_POS      = 3'd1;
   localparam logic [2:0] IDX_LAST     = 3'd2;
   localparam logic [2:0] IDX_FIRST_M1 = 3'd3;
   localparam logic [2:0] IDX_UP       = 3'd4;
   localparam logic [2:0] IDX_DOWN     = 3'd5;
   localparam logic [2:0] IDX_INC      = 3'd6;

   // Accumulator operations.
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_CLR  = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   // Jump conditions. A step whose condition holds jumps to its target,
   // otherwise the sequencer falls through to the next step.
   localparam logic [3:0] COND_NONE     = 4'd0;
   localparam logic [3:0] COND_ALWAYS   = 4'd1;
   localparam logic [3:0] COND_NO_REQ   = 4'd2;
   localparam logic [3:0] COND_SKIP     = 4'd3;
   localparam logic [3:0] COND_QUERY    = 4'd4;
   localparam logic [3:0] COND_IDX_OVER = 4'd5;
   localparam logic [3:0] COND_IDX_ZERO = 4'd6;
   localparam logic [3:0] COND_RSP_BUSY = 4'd7;
   localparam logic [3:0] COND_CLR_MORE = 4'd8;

   // Program step addresses.
   localparam upc_type STEP_CLR    = 4'd0;
   localparam upc_type STEP_GO     = 4'd1;
   localparam upc_type STEP_DONE   = 4'd2;
   localparam upc_type STEP_IDLE   = 4'd3;
   localparam upc_type STEP_DISP0  = 4'd4;
   localparam upc_type STEP_DISP1  = 4'd5;
   localparam upc_type STEP_U_EV   = 4'd6;
   localparam upc_type STEP_U_DLT  = 4'd7;
   localparam upc_type STEP_U_RD   = 4'd8;
   localparam upc_type STEP_U_WR   = 4'd9;
   localparam upc_type STEP_Q_RD1  = 4'd10;
   localparam upc_type STEP_Q_ACC1 = 4'd11;
   localparam upc_type STEP_Q_MID  = 4'd12;
   localparam upc_type STEP_Q_RD2  = 4'd13;
   localparam upc_type STEP_Q_ACC2 = 4'd14;

   typedef struct packed {
      logic       take;
      logic       ev_rd;
      logic       ev_wr;
      logic       ps_rd;
      logic       ps_wr;
      logic       zero_wr;
      logic       delta_ld;
      logic       rsp_ld;
      logic [2:0] idx_op;
      logic [1:0] acc_op;
      logic [3:0] cond;
      upc_type    target;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic skip;
      logic is_query;
      logic idx_over;
      logic idx_zero;
      logic rsp_busy;
      logic clr_more;
   } flags_type;

   function automatic ucode_type ucode_rom(input upc_type addr);
      ucode_type cw;
      cw = '0;
      unique case (addr)
         STEP_CLR: begin
            cw.zero_wr = 1'b1;
            cw.idx_op = IDX_INC;
            cw.cond = COND_CLR_MORE;
            cw.target = STEP_CLR;
         end
         STEP_GO: begin
            cw.cond = COND_ALWAYS;
            cw.target = STEP_IDLE;
         end
         STEP_DONE: begin
            cw.rsp_ld = 1'b1;
            cw.cond = COND_RSP_BUSY;
            cw.target = STEP_DONE;
         end
         STEP_IDLE: begin
            cw.take = 1'b1;
            cw.cond = COND_NO_REQ;
            cw.target = STEP_IDLE;
         end
         STEP_DISP0: begin
            cw.acc_op = ACC_CLR;
            cw.cond = COND_SKIP;
            cw.target = STEP_DONE;
         end
         STEP_DISP1: begin
            cw.idx_op = IDX_LAST;
            cw.cond = COND_QUERY;
            cw.target = STEP_Q_RD1;
         end
         STEP_U_EV: begin
            cw.ev_rd = 1'b1;
            cw.idx_op = IDX_POS;
         end
         STEP_U_DLT: begin
            cw.ev_wr = 1'b1;
            cw.delta_ld = 1'b1;
         end
         STEP_U_RD: begin
            cw.ps_rd = 1'b1;
            cw.cond = COND_IDX_OVER;
            cw.target = STEP_DONE;
         end
         STEP_U_WR: begin
            cw.ps_wr = 1'b1;
            cw.idx_op = IDX_UP;
            cw.cond = COND_ALWAYS;
            cw.target = STEP_U_RD;
         end
         STEP_Q_RD1: begin
            cw.ps_rd = 1'b1;
            cw.cond = COND_IDX_ZERO;
            cw.target = STEP_Q_MID;
         end
         STEP_Q_ACC1: begin
            cw.acc_op = ACC_ADD;
            cw.idx_op = IDX_DOWN;
            cw.cond = COND_ALWAYS;
            cw.target = STEP_Q_RD1;
         end
         STEP_Q_MID: begin
            cw.idx_op = IDX_FIRST_M1;
         end
         STEP_Q_RD2: begin
            cw.ps_rd = 1'b1;
            cw.cond = COND_IDX_ZERO;
            cw.target = STEP_DONE;
         end
         STEP_Q_ACC2: begin
            cw.acc_op = ACC_SUB;
            cw.idx_op = IDX_DOWN;
            cw.cond = COND_ALWAYS;
            cw.target = STEP_Q_RD2;
         end
         default: begin
            cw.cond = COND_ALWAYS;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

[rtl/fwrs_req_if.sv]
interface fwrs_req_if;
   import fwrs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic [POS_W-1:0]         position;
   logic [POS_W-1:0]         first_position;
   logic [POS_W-1:0]         last_position;
   logic signed [DATA_W-1:0] operand_value;

   modport source (
      output valid, kind, position, first_position, last_position, operand_value,
      input  ready
   );

   modport sink (
      input  valid, kind, position, first_position, last_position, operand_value,
      output ready
   );
endinterface

[rtl/fwrs_rsp_if.sv]
interface fwrs_rsp_if;
   import fwrs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] range_sum;
   logic                     bad_index;

   modport source (
      output valid, range_sum, bad_index,
      input  ready
   );

   modport sink (
      input  valid, range_sum, bad_index,
      output ready
   );
endinterface

[rtl/fenwick_range_sum_table.sv]
// One transaction at a time: a new one is taken in the cycle after the result is loaded;
// each visited node costs a read step and a write or accumulate step on the tree RAM.
// Reset: synchronous; afterwards a clear pass zeroes both RAMs at addresses 0 to MAX_SIZE
// while req_chan.ready stays low; active_size returns to 1024.
module fenwick_range_sum_table #(
   parameter int unsigned MAX_SIZE = fwrs_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   fwrs_req_if.sink                      req_chan,
   fwrs_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [fwrs_pkg::POS_W-1:0]    csr_wr_data
);
   import fwrs_pkg::*;

   // The active size register. Growing it does not rebuild the tree, so nodes
   // above the old size only hold what later updates put there.
   logic [POS_W-1:0] active_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= ACTIVE_SIZE_RESET;
      end else if (csr_wr_en) begin
         active_size_ff <= csr_wr_data;
      end
   end

   // The sequencer steps through a small program held in a ROM. Each control
   // word drives the datapath: the walk index, the accumulator, the ports of the two
   // RAMs and the result register. Flags from the datapath steer the jumps.
   ucode_type cw;
   flags_type flags;

   fwrs_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .cw    (cw)
   );

   // The datapath keeps the tree nodes and the element values in two RAMs.
   // An update reads the old element, forms the delta, then reads and writes
   // each node upward; a query accumulates prefix(last) and subtracts
   // prefix(first - 1), with a read step and an accumulate step per node.
   fwrs_datapath #(
      .MAX_SIZE (MAX_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cw          (cw),
      .active_size (active_size_ff),
      .flags       (flags),
      .req         (req_chan),
      .rsp         (rsp_chan)
   );

   // A transaction is taken only in the idle step, so ready drops right after.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken twice in a row");

   // After reset the clear pass runs before any transaction is taken.
   assert property (@(posedge clock) reset |=> !req_chan.ready)
      else $error("request taken during the clear pass");

   // Loading a result into a free output register makes it visible.
   assert property (@(posedge clock) disable iff (reset)
      (cw.rsp_ld && !(rsp_chan.valid && !rsp_chan.ready)) |=> rsp_chan.valid)
      else $error("result load was lost");
endmodule

[rtl/fwrs_ram.sv]
module fwrs_ram #(
   parameter int unsigned DEPTH = 1025
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [fwrs_pkg::DATA_W-1:0]      wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [fwrs_pkg::DATA_W-1:0]      rd_data
);
   import fwrs_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/fwrs_sequencer.sv]
module fwrs_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  fwrs_pkg::flags_type  flags,
   output fwrs_pkg::ucode_type  cw
);
   import fwrs_pkg::*;

   upc_type pc_ff;
   upc_type pc_in;
   logic    taken;

   assign cw = ucode_rom(pc_ff);

   always_comb begin
      unique case (cw.cond)
         COND_NONE:     taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_REQ:   taken = flags.no_req;
         COND_SKIP:     taken = flags.skip;
         COND_QUERY:    taken = flags.is_query;
         COND_IDX_OVER: taken = flags.idx_over;
         COND_IDX_ZERO: taken = flags.idx_zero;
         COND_RSP_BUSY: taken = flags.rsp_busy;
         COND_CLR_MORE: taken = flags.clr_more;
         default:       taken = 1'b0;
      endcase
      pc_in = taken ? cw.target : pc_ff + upc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end
endmodule

[rtl/fwrs_datapath.sv]
module fwrs_datapath #(
   parameter int unsigned MAX_SIZE = fwrs_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fwrs_pkg::ucode_type           cw,
   input  logic [fwrs_pkg::POS_W-1:0]    active_size,
   output fwrs_pkg::flags_type           flags,
   fwrs_req_if.sink                      req,
   fwrs_rsp_if.source                    rsp
);
   import fwrs_pkg::*;

   localparam int unsigned IW = $clog2(MAX_SIZE + 1);
   localparam int unsigned WW = IW + 1;
   localparam int unsigned CW = (WW > POS_W + 1) ? WW : POS_W + 1;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SIZE);

   logic [CW-1:0] size_c;
   logic [CW-1:0] eff_size;

   logic [1:0]        kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  first_ff;
   logic [POS_W-1:0]  last_ff;
   logic [DATA_W-1:0] val_ff;
   logic              bad_ff;
   logic              bad_in;
   logic [WW-1:0]     idx_ff;
   logic [WW-1:0]     idx_in;
   logic [WW-1:0]     lowbit;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;
   logic [DATA_W-1:0] delta_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_sum_ff;
   logic              rsp_bad_ff;

   logic              accept;
   logic [CW-1:0]     pos_c;
   logic [CW-1:0]     first_c;
   logic [CW-1:0]     last_c;

   logic              ps_wr_en;
   logic [DATA_W-1:0] ps_wr_data;
   logic [DATA_W-1:0] ps_rd_data;
   logic              ev_wr_en;
   logic [IW-1:0]     ev_wr_addr;
   logic [DATA_W-1:0] ev_wr_data;
   logic [DATA_W-1:0] ev_rd_data;

   function automatic logic pos_ok(input logic [POS_W-1:0] p, input logic [CW-1:0] n);
      return (p != '0) && (CW'(p) <= n);
   endfunction

   assign size_c   = CW'(active_size);
   assign eff_size = (size_c > MAX_C) ? MAX_C : size_c;

   assign accept    = cw.take && req.valid;
   assign req.ready = cw.take;

   assign pos_c   = CW'(pos_ff);
   assign first_c = CW'(first_ff);
   assign last_c  = CW'(last_ff);

   always_comb begin
      case (req.kind) inside
         KIND_ADD, KIND_SET: bad_in = !pos_ok(req.position, eff_size);
         KIND_QUERY: bad_in = !pos_ok(req.first_position, eff_size) ||
                              !pos_ok(req.last_position, eff_size);
         default: bad_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req.kind;
         pos_ff   <= req.position;
         first_ff <= req.first_position;
         last_ff  <= req.last_position;
         val_ff   <= req.operand_value;
         bad_ff   <= bad_in;
      end
   end

   // Walk index: lowest set bit steps up for updates and down for prefix sums.
   assign lowbit = idx_ff & (~idx_ff + WW'(1));

   always_comb begin
      case (cw.idx_op)
         IDX_POS:      idx_in = pos_c[WW-1:0];
         IDX_LAST:     idx_in = last_c[WW-1:0];
         IDX_FIRST_M1: idx_in = first_c[WW-1:0] - WW'(1);
         IDX_UP:       idx_in = idx_ff + lowbit;
         IDX_DOWN:     idx_in = idx_ff - lowbit;
         IDX_INC:      idx_in = idx_ff + WW'(1);
         default:      idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      case (cw.acc_op)
         ACC_CLR: acc_in = '0;
         ACC_ADD: acc_in = acc_ff + ps_rd_data;
         ACC_SUB: acc_in = acc_ff - ps_rd_data;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cw.delta_ld) begin
         delta_ff <= (kind_ff == KIND_SET) ? val_ff - ev_rd_data : val_ff;
      end
   end

   // Tree nodes and element values; the clear pass writes zeros to both.
   assign ps_wr_en   = cw.ps_wr || cw.zero_wr;
   assign ps_wr_data = cw.zero_wr ? '0 : ps_rd_data + delta_ff;

   assign ev_wr_en   = cw.ev_wr || cw.zero_wr;
   assign ev_wr_addr = cw.zero_wr ? idx_ff[IW-1:0] : pos_c[IW-1:0];
   assign ev_wr_data = cw.zero_wr ? '0 :
                       (kind_ff == KIND_SET) ? val_ff : ev_rd_data + val_ff;

   fwrs_ram #(
      .DEPTH (MAX_SIZE + 1)
   ) u_ps_ram (
      .clock   (clock),
      .wr_en   (ps_wr_en),
      .wr_addr (idx_ff[IW-1:0]),
      .wr_data (ps_wr_data),
      .rd_en   (cw.ps_rd && !flags.idx_over),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ps_rd_data)
   );

   fwrs_ram #(
      .DEPTH (MAX_SIZE + 1)
   ) u_ev_ram (
      .clock   (clock),
      .wr_en   (ev_wr_en),
      .wr_addr (ev_wr_addr),
      .wr_data (ev_wr_data),
      .rd_en   (cw.ev_rd),
      .rd_addr (pos_c[IW-1:0]),
      .rd_data (ev_rd_data)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cw.rsp_ld && !flags.rsp_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cw.rsp_ld && !flags.rsp_busy) begin
         rsp_sum_ff <= acc_ff;
         rsp_bad_ff <= bad_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.range_sum = rsp_sum_ff;
   assign rsp.bad_index = rsp_bad_ff;

   assign flags.no_req   = !req.valid;
   assign flags.skip     = bad_ff || (kind_ff == KIND_NONE);
   assign flags.is_query = (kind_ff == KIND_QUERY);
   assign flags.idx_over = CW'(idx_ff) > eff_size;
   assign flags.idx_zero = (idx_ff == '0);
   assign flags.rsp_busy = rsp_valid_ff && !rsp.ready;
   assign flags.clr_more = (idx_ff != WW'(MAX_SIZE));
endmodule
